FILE: hw/rtl/nklf_pkg.sv
`timescale 1ns / 1ps

package nklf_pkg;

   // fixed field widths of the channels
   localparam int GENE_BITS      = 5;
   localparam int ENTRY_BITS     = 5;
   localparam int CONTRIB_BITS   = 16;
   localparam int GENOME_BITS    = 32;
   localparam int FITNESS_BITS   = 21;
   localparam int GENES_CFG_BITS = 6;
   localparam int NBRS_CFG_BITS  = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 6;

   typedef enum logic [1:0] {
      ACT_WR_CONTRIB,
      ACT_WR_NEIGHBOR,
      ACT_EVALUATE
   } action_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GENES_IN_USE,
      CSR_NEIGHBOR_COUNT
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DRAIN
   } seq_state_type;

   typedef struct packed {
      logic [GENES_CFG_BITS-1:0] genes_in_use;
      logic [NBRS_CFG_BITS-1:0]  neighbor_count;
   } cfg_type;

   // table write request, enables already qualified by range checks
   typedef struct packed {
      logic                    contrib_we;
      logic                    neighbor_we;
      logic [GENE_BITS-1:0]    gene;
      logic [ENTRY_BITS-1:0]   entry;
      logic [CONTRIB_BITS-1:0] contribution;
      logic [GENE_BITS-1:0]    neighbor_gene;
   } wr_type;

   typedef struct packed {
      logic idle;
      logic done;
   } seq_stat_type;

endpackage

FILE: hw/rtl/nklf_if.sv
`timescale 1ns / 1ps

interface nklf_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          action;
   logic [nklf_pkg::GENE_BITS-1:0]      gene_index;
   logic [nklf_pkg::ENTRY_BITS-1:0]     entry_index;
   logic [nklf_pkg::CONTRIB_BITS-1:0]   contribution;
   logic [nklf_pkg::GENE_BITS-1:0]      neighbor_gene;
   logic [nklf_pkg::GENOME_BITS-1:0]    genome;

   modport source (output valid, action, gene_index, entry_index, contribution,
                   neighbor_gene, genome, input ready);
   modport sink   (input valid, action, gene_index, entry_index, contribution,
                   neighbor_gene, genome, output ready);
endinterface

interface nklf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [nklf_pkg::FITNESS_BITS-1:0] fitness;

   modport source (output valid, fitness, input ready);
   modport sink   (input valid, fitness, output ready);
endinterface

interface nklf_csr_if;
   logic                                valid;
   logic                                ready;
   logic [nklf_pkg::CSR_INDEX_BITS-1:0] index;
   logic [nklf_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/nklf_nbr_ram.sv
`timescale 1ns / 1ps

module nklf_nbr_ram #(
   parameter int MAX_GENES     = 32,
   parameter int MAX_NEIGHBORS = 4
) (
   input  logic                                               clock,
   input  nklf_pkg::wr_type                                   wr,
   input  logic                                               rd_en,
   input  logic [$clog2(MAX_GENES)-1:0]                       rd_addr,
   output logic [MAX_NEIGHBORS-1:0][nklf_pkg::GENE_BITS-1:0]  rd_row
);

   localparam int GA = $clog2(MAX_GENES);

   // one row per gene, one slot per neighbor, slot-wise write enable
   logic [MAX_NEIGHBORS-1:0][nklf_pkg::GENE_BITS-1:0] mem [MAX_GENES];
   logic [MAX_NEIGHBORS-1:0][nklf_pkg::GENE_BITS-1:0] rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr.neighbor_we) begin
         for (int j = 0; j < MAX_NEIGHBORS; j++) begin
            if (wr.entry == nklf_pkg::ENTRY_BITS'(j)) begin
               mem[GA'(wr.gene)][j] <= wr.neighbor_gene;
            end
         end
      end
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

FILE: hw/rtl/nklf_val_ram.sv
`timescale 1ns / 1ps

module nklf_val_ram #(
   parameter int MAX_GENES     = 32,
   parameter int MAX_NEIGHBORS = 4,
   parameter int VALUE_BITS    = 16
) (
   input  logic                                            clock,
   input  nklf_pkg::wr_type                                wr,
   input  logic                                            rd_en,
   input  logic [$clog2(MAX_GENES)+MAX_NEIGHBORS:0]        rd_addr,
   output logic [VALUE_BITS-1:0]                           rd_data
);

   localparam int GA    = $clog2(MAX_GENES);
   localparam int IW    = MAX_NEIGHBORS + 1;
   localparam int DEPTH = MAX_GENES * (2 ** IW);

   logic [VALUE_BITS-1:0] mem [DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.contrib_we) begin
         mem[{GA'(wr.gene), IW'(wr.entry)}] <= VALUE_BITS'(wr.contribution);
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/nklf_seq.sv
`timescale 1ns / 1ps

module nklf_seq #(
   parameter int MAX_GENES     = 32,
   parameter int MAX_NEIGHBORS = 4,
   parameter int VALUE_BITS    = 16
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               start,
   input  logic [nklf_pkg::GENOME_BITS-1:0]                   genome,
   input  nklf_pkg::cfg_type                                  cfg,
   input  logic                                               rsp_free,
   output logic                                               nbr_rd,
   output logic [$clog2(MAX_GENES)-1:0]                       nbr_addr,
   input  logic [MAX_NEIGHBORS-1:0][nklf_pkg::GENE_BITS-1:0]  nbr_row,
   output logic                                               val_rd,
   output logic [$clog2(MAX_GENES)+MAX_NEIGHBORS:0]           val_addr,
   input  logic [VALUE_BITS-1:0]                              val_data,
   output nklf_pkg::seq_stat_type                             stat,
   output logic [nklf_pkg::FITNESS_BITS-1:0]                  fitness
);

   localparam int GA = $clog2(MAX_GENES);
   localparam int IW = MAX_NEIGHBORS + 1;
   localparam int CW = $clog2(MAX_GENES + 1);
   localparam int KW = $clog2(MAX_NEIGHBORS + 1);

   nklf_pkg::seq_state_type state_ff, state_in;

   logic [GA-1:0]                        cnt_ff, cnt_in;
   logic [nklf_pkg::GENOME_BITS-1:0]     genome_ff, genome_in;
   logic [nklf_pkg::FITNESS_BITS-1:0]    acc_ff, acc_in;
   logic                                 s1_vld_ff, s1_vld_in;
   logic [GA-1:0]                        s1_gene_ff;
   logic                                 s1_own_ff;
   logic                                 s2_vld_ff;
   logic                                 issue;
   logic [CW-1:0]                        n_sat;
   logic [KW-1:0]                        k_sat;
   logic [nklf_pkg::GENOME_BITS-1:0]     own_shift;
   logic [IW-1:0]                        idx;

   assign n_sat = (cfg.genes_in_use > MAX_GENES) ? CW'(MAX_GENES) : CW'(cfg.genes_in_use);
   assign k_sat = (cfg.neighbor_count > MAX_NEIGHBORS) ? KW'(MAX_NEIGHBORS)
                                                       : KW'(cfg.neighbor_count);

   // own bit of the gene, zero for genes beyond the genome width
   assign own_shift = genome_ff >> cnt_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      genome_in = genome_ff;
      acc_in    = acc_ff;
      issue     = 1'b0;
      stat      = '0;
      case (state_ff)
         nklf_pkg::S_IDLE: begin
            stat.idle = 1'b1;
            if (start) begin
               genome_in = genome;
               cnt_in    = '0;
               acc_in    = '0;
               state_in  = (n_sat == '0) ? nklf_pkg::S_DRAIN : nklf_pkg::S_RUN;
            end
         end
         nklf_pkg::S_RUN: begin
            issue  = 1'b1;
            cnt_in = cnt_ff + GA'(1);
            if (CW'(cnt_ff) + CW'(1) == n_sat) begin
               state_in = nklf_pkg::S_DRAIN;
            end
         end
         nklf_pkg::S_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff && rsp_free) begin
               stat.done = 1'b1;
               state_in  = nklf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = nklf_pkg::S_IDLE;
         end
      endcase
      if (s2_vld_ff) begin
         acc_in = acc_ff + nklf_pkg::FITNESS_BITS'(val_data);
      end
   end

   // stage b: own bit first, then neighbor slots in order
   always_comb begin
      idx    = '0;
      idx[0] = s1_own_ff;
      for (int j = 0; j < MAX_NEIGHBORS; j++) begin
         if (j < k_sat) begin
            idx = {idx[IW-2:0], genome_ff[nbr_row[j]]};
         end
      end
   end

   assign s1_vld_in = issue;
   assign nbr_rd    = issue;
   assign nbr_addr  = cnt_ff;
   assign val_rd    = s1_vld_ff;
   assign val_addr  = {s1_gene_ff, idx};
   assign fitness   = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= nklf_pkg::S_IDLE;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      genome_ff  <= genome_in;
      acc_ff     <= acc_in;
      s1_gene_ff <= cnt_ff;
      s1_own_ff  <= own_shift[0];
   end

endmodule

FILE: hw/rtl/nk_landscape_fitness_unit.sv
`timescale 1ns / 1ps

// channel   modport  handshake     payload
// req_ch    sink     valid/ready   action, gene_index, entry_index, contribution,
//                                  neighbor_gene, genome
// rsp_ch    source   valid/ready   fitness
// csr_ch    sink     valid/ready   index, data (0 genes_in_use, 1 neighbor_count)
//
// a write transaction is done when accepted; an evaluate transaction holds the block
// busy from acceptance until its result is loaded into the output register, walking
// N, the saturated genes in use, with one contribution lookup per gene through the
// single read port of the value memory; sync reset clears control and
// sets config to 32 genes, 2 neighbors; both tables are undefined until written
// a pending fitness in the output register does not block new transactions; a
// finished evaluation waits in the drain state until the output register frees

module nk_landscape_fitness_unit #(
   parameter int MAX_GENES     = 32,
   parameter int MAX_NEIGHBORS = 4,
   parameter int VALUE_BITS    = 16
) (
   input logic        clock,
   input logic        reset,
   nklf_req_if.sink   req_ch,
   nklf_rsp_if.source rsp_ch,
   nklf_csr_if.sink   csr_ch
);

   localparam int GA     = $clog2(MAX_GENES);
   localparam int IW     = MAX_NEIGHBORS + 1;
   localparam int STRIDE = 2 ** IW;

   // configuration registers
   logic [nklf_pkg::GENES_CFG_BITS-1:0] genes_ff, genes_in;
   logic [nklf_pkg::NBRS_CFG_BITS-1:0]  nbrs_ff, nbrs_in;
   nklf_pkg::cfg_type                   cfg;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [nklf_pkg::FITNESS_BITS-1:0] fitness_ff, fitness_in;
   logic                              rsp_free;

   logic                   req_fire;
   nklf_pkg::wr_type       wr;
   nklf_pkg::seq_stat_type stat;
   logic                   start;

   logic                                              nbr_rd;
   logic [GA-1:0]                                     nbr_addr;
   logic [MAX_NEIGHBORS-1:0][nklf_pkg::GENE_BITS-1:0] nbr_row;
   logic                                              val_rd;
   logic [GA+IW-1:0]                                  val_addr;
   logic [VALUE_BITS-1:0]                             val_data;
   logic [nklf_pkg::FITNESS_BITS-1:0]                 seq_fitness;

   // config writes are always taken; unknown indexes fall through
   assign csr_ch.ready = 1'b1;

   always_comb begin
      genes_in = genes_ff;
      nbrs_in  = nbrs_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            nklf_pkg::CSR_GENES_IN_USE: begin
               genes_in = csr_ch.data[nklf_pkg::GENES_CFG_BITS-1:0];
            end
            nklf_pkg::CSR_NEIGHBOR_COUNT: begin
               nbrs_in = csr_ch.data[nklf_pkg::NBRS_CFG_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.genes_in_use   = genes_ff;
   assign cfg.neighbor_count = nbrs_ff;

   // a new transaction is taken whenever the sequencer is idle
   assign req_ch.ready = stat.idle;
   assign req_fire     = req_ch.valid && stat.idle;
   assign start        = req_fire && (req_ch.action == nklf_pkg::ACT_EVALUATE);

   // write decode with range checks; out-of-range writes are dropped
   always_comb begin
      wr.contrib_we    = req_fire && (req_ch.action == nklf_pkg::ACT_WR_CONTRIB)
                         && (32'(req_ch.gene_index) < MAX_GENES)
                         && (32'(req_ch.entry_index) < STRIDE);
      wr.neighbor_we   = req_fire && (req_ch.action == nklf_pkg::ACT_WR_NEIGHBOR)
                         && (32'(req_ch.gene_index) < MAX_GENES)
                         && (32'(req_ch.entry_index) < MAX_NEIGHBORS);
      wr.gene          = req_ch.gene_index;
      wr.entry         = req_ch.entry_index;
      wr.contribution  = req_ch.contribution;
      wr.neighbor_gene = req_ch.neighbor_gene;
   end

   nklf_nbr_ram #(
      .MAX_GENES     (MAX_GENES),
      .MAX_NEIGHBORS (MAX_NEIGHBORS)
   ) u_nbr_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (nbr_rd),
      .rd_addr (nbr_addr),
      .rd_row  (nbr_row)
   );

   nklf_val_ram #(
      .MAX_GENES     (MAX_GENES),
      .MAX_NEIGHBORS (MAX_NEIGHBORS),
      .VALUE_BITS    (VALUE_BITS)
   ) u_val_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (val_rd),
      .rd_addr (val_addr),
      .rd_data (val_data)
   );

   // gene walk: neighbor row read, index build and value read, accumulate
   nklf_seq #(
      .MAX_GENES     (MAX_GENES),
      .MAX_NEIGHBORS (MAX_NEIGHBORS),
      .VALUE_BITS    (VALUE_BITS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .genome   (req_ch.genome),
      .cfg      (cfg),
      .rsp_free (rsp_free),
      .nbr_rd   (nbr_rd),
      .nbr_addr (nbr_addr),
      .nbr_row  (nbr_row),
      .val_rd   (val_rd),
      .val_addr (val_addr),
      .val_data (val_data),
      .stat     (stat),
      .fitness  (seq_fitness)
   );

   // output register frees in the cycle its transaction completes
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      fitness_in   = fitness_ff;
      if (stat.done) begin
         rsp_valid_in = 1'b1;
         fitness_in   = seq_fitness;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.fitness = fitness_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         genes_ff     <= nklf_pkg::GENES_CFG_BITS'(32);
         nbrs_ff      <= nklf_pkg::NBRS_CFG_BITS'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         genes_ff     <= genes_in;
         nbrs_ff      <= nbrs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fitness_ff <= fitness_in;
   end

endmodule

FILE: hw/rtl/nklf_checker.sv
`timescale 1ns / 1ps

module nklf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [1:0]                        req_action,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [nklf_pkg::FITNESS_BITS-1:0] rsp_fitness
);

   logic req_fire;
   logic eval_fire;

   assign req_fire  = req_valid && req_ready;
   assign eval_fire = req_fire && (req_action == nklf_pkg::ACT_EVALUATE);

   // stalled response keeps its valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_fitness))
      else $error("response payload changed while stalled");

   // an evaluate occupies the block
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      eval_fire |=> !req_ready)
      else $error("new transaction taken during evaluation");

   // table writes never produce a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_action != nklf_pkg::ACT_EVALUATE) |=> !$rose(rsp_valid))
      else $error("response raised by a write transaction");

   // no response can follow an evaluate in the very next cycle
   a_eval_latency: assert property (@(posedge clock) disable iff (reset)
      eval_fire && !rsp_valid |=> !rsp_valid)
      else $error("fitness appeared too early");

endmodule

bind nk_landscape_fitness_unit nklf_checker u_nklf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_action  (req_ch.action),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_fitness (rsp_ch.fitness)
);

FILE: test/nk_landscape_fitness_unit_tb.sv
`timescale 1ns / 1ps

module nk_landscape_fitness_unit_tb;

   // block configuration under test
   localparam int MAX_GENES     = 32;
   localparam int MAX_NEIGHBORS = 4;
   localparam int VALUE_BITS    = 16;
   localparam int TABLE_DEPTH   = 1 << (MAX_NEIGHBORS + 1);

   // channel field widths
   localparam int GENE_BITS      = nklf_pkg::GENE_BITS;
   localparam int ENTRY_BITS     = nklf_pkg::ENTRY_BITS;
   localparam int CONTRIB_BITS   = nklf_pkg::CONTRIB_BITS;
   localparam int GENOME_BITS    = nklf_pkg::GENOME_BITS;
   localparam int FITNESS_BITS   = nklf_pkg::FITNESS_BITS;
   localparam int GENES_CFG_BITS = nklf_pkg::GENES_CFG_BITS;
   localparam int NBRS_CFG_BITS  = nklf_pkg::NBRS_CFG_BITS;
   localparam int CSR_INDEX_BITS = nklf_pkg::CSR_INDEX_BITS;
   localparam int CSR_DATA_BITS  = nklf_pkg::CSR_DATA_BITS;

   // run shape
   localparam int TOTAL_ITEMS    = 1650;
   localparam int PHASE_ITEMS    = 150;
   localparam int MAX_GAP        = 14;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 48;
   localparam int STALL_LIMIT    = 3000;
   localparam int PRESSURE_EVALS = 24;

   // codes outside the package enums
   localparam logic [1:0]                ACT_UNKNOWN  = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct {
      logic [1:0]              action;
      logic [GENE_BITS-1:0]    gene_index;
      logic [ENTRY_BITS-1:0]   entry_index;
      logic [CONTRIB_BITS-1:0] contribution;
      logic [GENE_BITS-1:0]    neighbor_gene;
      logic [GENOME_BITS-1:0]  genome;
   } request_type;

   logic clock;
   logic reset;

   nklf_req_if req_if ();
   nklf_rsp_if rsp_if ();
   nklf_csr_if csr_if ();

   nk_landscape_fitness_unit #(
      .MAX_GENES    (MAX_GENES),
      .MAX_NEIGHBORS(MAX_NEIGHBORS),
      .VALUE_BITS   (VALUE_BITS)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_ch(csr_if)
   );

   // shadow copy of the block state, updated on each accepted transaction
   logic [CONTRIB_BITS-1:0]   contrib_mem     [MAX_GENES][TABLE_DEPTH];
   logic [GENE_BITS-1:0]      neighbor_mem    [MAX_GENES][MAX_NEIGHBORS];
   bit                        contrib_loaded  [MAX_GENES][TABLE_DEPTH];
   bit                        neighbor_loaded [MAX_GENES][MAX_NEIGHBORS];
   logic [GENES_CFG_BITS-1:0] genes_cfg     = 6'd32;
   logic [NBRS_CFG_BITS-1:0]  neighbors_cfg = 3'd2;

   // fitness values still owed by the block, oldest first
   logic [FITNESS_BITS-1:0] pending_fitness [$];

   int unsigned req_max_gap     = MAX_GAP;
   int unsigned rsp_max_gap     = MAX_GAP;
   int unsigned rsp_hold_cycles = 0;
   int unsigned sent_count      = 0;
   int unsigned mismatch_count  = 0;
   int unsigned idle_cycles     = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // genes in use and neighbor count both saturate at the table limits
   function automatic int active_genes();
      return (int'(genes_cfg) > MAX_GENES) ? MAX_GENES : int'(genes_cfg);
   endfunction

   function automatic int active_neighbors();
      return (int'(neighbors_cfg) > MAX_NEIGHBORS) ? MAX_NEIGHBORS : int'(neighbors_cfg);
   endfunction

   // own bit on top, then one bit per neighbor slot in slot order
   function automatic int table_index(logic [GENOME_BITS-1:0] genome, int gene);
      int idx;
      idx = int'(genome[gene]);
      for (int j = 0; j < active_neighbors(); j++)
         idx = (idx << 1) | int'(genome[neighbor_mem[gene][j]]);
      return idx & (TABLE_DEPTH - 1);
   endfunction

   // sum wraps at the fitness width
   function automatic logic [FITNESS_BITS-1:0] predict_fitness(logic [GENOME_BITS-1:0] genome);
      logic [FITNESS_BITS-1:0] sum;
      sum = '0;
      for (int i = 0; i < active_genes(); i++)
         sum += FITNESS_BITS'(contrib_mem[i][table_index(genome, i)]);
      return sum;
   endfunction

   // ------------------------------------------------------------------
   // drivers: inputs change on the falling edge
   // ------------------------------------------------------------------

   // every field random, so that fields the action ignores still toggle
   function automatic request_type random_request(logic [1:0] action);
      request_type req;
      req.action        = action;
      req.gene_index    = GENE_BITS'($urandom);
      req.entry_index   = ENTRY_BITS'($urandom);
      req.contribution  = CONTRIB_BITS'($urandom);
      req.neighbor_gene = GENE_BITS'($urandom);
      req.genome        = $urandom;
      return req;
   endfunction

   // offer one transaction; returns right after the accepting edge
   task automatic send_request(request_type req);
      int unsigned gap;
      gap = $urandom_range(req_max_gap);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.action        <= req.action;
      req_if.gene_index    <= req.gene_index;
      req_if.entry_index   <= req.entry_index;
      req_if.contribution  <= req.contribution;
      req_if.neighbor_gene <= req.neighbor_gene;
      req_if.genome        <= req.genome;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      // shadow state follows the accepted transaction
      case (req.action)
         nklf_pkg::ACT_WR_CONTRIB: begin
            if (int'(req.gene_index) < MAX_GENES && int'(req.entry_index) < TABLE_DEPTH) begin
               contrib_mem[req.gene_index][req.entry_index]    = req.contribution;
               contrib_loaded[req.gene_index][req.entry_index] = 1'b1;
            end
         end
         nklf_pkg::ACT_WR_NEIGHBOR: begin
            if (int'(req.gene_index) < MAX_GENES && int'(req.entry_index) < MAX_NEIGHBORS) begin
               neighbor_mem[req.gene_index][int'(req.entry_index)]    = req.neighbor_gene;
               neighbor_loaded[req.gene_index][int'(req.entry_index)] = 1'b1;
            end
         end
         nklf_pkg::ACT_EVALUATE: begin
            pending_fitness.push_back(predict_fitness(req.genome));
         end
         default: ;
      endcase
      if (req.action != ACT_UNKNOWN) sent_count++;
   endtask

   // drop valid, drain all owed results, then let a trailing write finish
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_fitness.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // register writes only go out with the block idle
   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
      settle();
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (index)
         nklf_pkg::CSR_GENES_IN_USE:   genes_cfg     = data;
         nklf_pkg::CSR_NEIGHBOR_COUNT: neighbors_cfg = data[NBRS_CFG_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // upper data bits of the neighbor count are junk the block must drop
   task automatic configure(int genes, int neighbors);
      logic [CSR_DATA_BITS-1:0] data;
      write_csr(nklf_pkg::CSR_GENES_IN_USE, CSR_DATA_BITS'(genes));
      data = CSR_DATA_BITS'($urandom);
      data[NBRS_CFG_BITS-1:0] = NBRS_CFG_BITS'(neighbors);
      write_csr(nklf_pkg::CSR_NEIGHBOR_COUNT, data);
   endtask

   // load whatever the genome will look up that was never written, then evaluate
   task automatic evaluate_genome(logic [GENOME_BITS-1:0] genome);
      request_type req;
      int idx;
      for (int i = 0; i < active_genes(); i++) begin
         for (int j = 0; j < active_neighbors(); j++) begin
            if (!neighbor_loaded[i][j]) begin
               req = random_request(nklf_pkg::ACT_WR_NEIGHBOR);
               req.gene_index  = GENE_BITS'(i);
               req.entry_index = ENTRY_BITS'(j);
               send_request(req);
            end
         end
      end
      for (int i = 0; i < active_genes(); i++) begin
         idx = table_index(genome, i);
         if (!contrib_loaded[i][idx]) begin
            req = random_request(nklf_pkg::ACT_WR_CONTRIB);
            req.gene_index  = GENE_BITS'(i);
            req.entry_index = ENTRY_BITS'(idx);
            send_request(req);
         end
      end
      req = random_request(nklf_pkg::ACT_EVALUATE);
      req.genome = genome;
      send_request(req);
   endtask

   // ------------------------------------------------------------------
   // result side: ready changes on the falling edge, sampled on the rising
   // ------------------------------------------------------------------

   initial begin : result_sink
      int unsigned gap;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         // a requested long hold replaces the usual random gap
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = $urandom_range(rsp_max_gap);
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // compare each accepted fitness against the oldest prediction
   always @(posedge clock) begin : fitness_check
      logic [FITNESS_BITS-1:0] expected;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_fitness.size() == 0) begin
            $display("%0t ns: fitness expected none, actual %0d", $time, rsp_if.fitness);
            mismatch_count++;
         end else begin
            expected = pending_fitness.pop_front();
            if (rsp_if.fitness !== expected) begin
               $display("%0t ns: fitness expected %0d, actual %0d",
                        $time, expected, rsp_if.fitness);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: any transaction on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset defaults: 32 genes, 2 neighbors
   task automatic test_reset_config();
      evaluate_genome('1);
      evaluate_genome('0);
      evaluate_genome($urandom);
   endtask

   // largest possible sum, and a zero sum
   task automatic test_max_fitness();
      request_type req;
      configure(MAX_GENES, 0);
      for (int i = 0; i < MAX_GENES; i++) begin
         req = random_request(nklf_pkg::ACT_WR_CONTRIB);
         req.gene_index   = GENE_BITS'(i);
         req.entry_index  = ENTRY_BITS'(1);
         req.contribution = '1;
         send_request(req);
         req = random_request(nklf_pkg::ACT_WR_CONTRIB);
         req.gene_index   = GENE_BITS'(i);
         req.entry_index  = '0;
         req.contribution = '0;
         send_request(req);
      end
      evaluate_genome('1);
      evaluate_genome('0);
      evaluate_genome(32'h5555_5555);
   endtask

   // zero genes, saturating genes and neighbors, single gene
   task automatic test_config_extremes();
      configure(0, 7);
      evaluate_genome($urandom);
      evaluate_genome('1);
      configure(63, 7);
      evaluate_genome($urandom);
      evaluate_genome('1);
      configure(1, 0);
      evaluate_genome('1);
      configure(MAX_GENES + 1, MAX_NEIGHBORS + 1);
      evaluate_genome($urandom);
   endtask

   // neighbor past genes in use, dropped slot write, unknown action, spare register
   task automatic test_corner_cases();
      request_type req;
      logic [CSR_DATA_BITS-1:0] junk;
      configure(4, 1);
      evaluate_genome($urandom);
      req = random_request(nklf_pkg::ACT_WR_NEIGHBOR);
      req.gene_index    = '0;
      req.entry_index   = '0;
      req.neighbor_gene = '1;
      send_request(req);
      evaluate_genome(32'h8000_0000);
      evaluate_genome(32'h0000_000f);
      // slot just past the list must not alias slot 0
      req = random_request(nklf_pkg::ACT_WR_NEIGHBOR);
      req.gene_index    = '0;
      req.entry_index   = ENTRY_BITS'(MAX_NEIGHBORS);
      req.neighbor_gene = GENE_BITS'(1);
      send_request(req);
      evaluate_genome(32'h8000_0000);
      evaluate_genome(32'h0000_0002);
      send_request(random_request(ACT_UNKNOWN));
      evaluate_genome($urandom);
      junk = CSR_DATA_BITS'($urandom);
      write_csr(CSR_UNMAPPED, junk);
      evaluate_genome($urandom);
   endtask

   // results back up while the sender keeps pushing evaluations
   task automatic test_back_pressure();
      configure(MAX_GENES, MAX_NEIGHBORS);
      req_max_gap     = 0;
      rsp_hold_cycles = LONG_HOLD;
      repeat (PRESSURE_EVALS) evaluate_genome($urandom);
      settle();
      req_max_gap = MAX_GAP;
   endtask

   // phases of random traffic, each under its own configuration, up to the item budget
   task automatic test_random_traffic();
      int genes_choice [6] = '{32, 1, 63, 0, 7, 20};
      int nbrs_choice  [6] = '{4, 0, 7, 2, 5, 3};
      int unsigned target;
      int unsigned roll;
      int phase;
      logic [GENOME_BITS-1:0] genome;
      request_type req;
      target = TOTAL_ITEMS;
      phase  = 0;
      while (sent_count < target) begin
         if (phase < 6)
            configure(genes_choice[phase], nbrs_choice[phase]);
         else
            configure($urandom_range(63), $urandom_range(7));
         // some phases run back to back on one or both sides
         req_max_gap = ($urandom_range(3) == 0) ? 0 : MAX_GAP;
         rsp_max_gap = ($urandom_range(3) == 0) ? 0 : MAX_GAP;
         repeat (PHASE_ITEMS) begin
            if (sent_count >= target) break;
            roll = $urandom_range(99);
            if (roll < 70) begin
               case ($urandom_range(7))
                  0:       genome = '0;
                  1:       genome = '1;
                  2:       genome = GENOME_BITS'(1) << $urandom_range(GENOME_BITS - 1);
                  default: genome = $urandom;
               endcase
               evaluate_genome(genome);
            end else if (roll < 82) begin
               send_request(random_request(nklf_pkg::ACT_WR_CONTRIB));
            end else if (roll < 90) begin
               req = random_request(nklf_pkg::ACT_WR_NEIGHBOR);
               req.entry_index = ENTRY_BITS'($urandom_range(MAX_NEIGHBORS - 1));
               send_request(req);
            end else if (roll < 95) begin
               // slot outside the neighbor list, dropped
               req = random_request(nklf_pkg::ACT_WR_NEIGHBOR);
               req.entry_index = ENTRY_BITS'($urandom_range(31, MAX_NEIGHBORS));
               send_request(req);
            end else begin
               send_request(random_request(ACT_UNKNOWN));
            end
         end
         phase++;
      end
      req_max_gap = MAX_GAP;
      rsp_max_gap = MAX_GAP;
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.action        = '0;
      req_if.gene_index    = '0;
      req_if.entry_index   = '0;
      req_if.contribution  = '0;
      req_if.neighbor_gene = '0;
      req_if.genome        = '0;
      csr_if.valid         = 1'b0;
      csr_if.index         = '0;
      csr_if.data          = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_config();
      test_max_fitness();
      test_config_extremes();
      test_corner_cases();
      test_back_pressure();
      test_random_traffic();

      // drain and give the block time to show any stray result
      settle();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/nklf_pkg.sv
hw/rtl/nklf_if.sv
hw/rtl/nklf_nbr_ram.sv
hw/rtl/nklf_val_ram.sv
hw/rtl/nklf_seq.sv
hw/rtl/nk_landscape_fitness_unit.sv
hw/rtl/nklf_checker.sv
test/nk_landscape_fitness_unit_tb.sv
